[hdl/pidrs_pkg.sv]
// Package for the rate-scaled PID controller.
// Holds the number format, register indexes and the saturating helper functions.
// Used by pidrs_div and pid_controller_rate_scaled.
package pidrs_pkg;

  localparam int DW     = 32;
  localparam int FB     = 16;
  localparam int ADDR_W = 5;

  typedef logic signed [DW-1:0] data_t;
  typedef logic        [DW-1:0] mag_t;
  typedef logic        [DW-2:0] lim_t;
  typedef logic      [2*DW-1:0] prod_t;

  localparam data_t SMAX  = data_t'({1'b0, {(DW-1){1'b1}}});
  localparam data_t SMIN  = data_t'({1'b1, {(DW-1){1'b0}}});
  localparam mag_t  ONE_Q = {{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

  localparam logic [2:0] REG_P_GAIN   = 3'd0;
  localparam logic [2:0] REG_I_GAIN   = 3'd1;
  localparam logic [2:0] REG_D_GAIN   = 3'd2;
  localparam logic [2:0] REG_INT_LIM  = 3'd3;
  localparam logic [2:0] REG_DER_LIM  = 3'd4;
  localparam logic [2:0] REG_OUT_LIM  = 3'd5;

  function automatic data_t sat_add(data_t a, data_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return data_t'(s[DW-1:0]);
  endfunction

  function automatic data_t sat_sub(data_t a, data_t b);
    logic [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) return s[DW] ? SMIN : SMAX;
    return data_t'(s[DW-1:0]);
  endfunction

  function automatic data_t clamp(data_t x, lim_t lim);
    data_t hi;
    data_t lo;
    hi = data_t'({1'b0, lim});
    lo = -hi;
    if (lim == '0) return x;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic mag_t mag(data_t x);
    return x[DW-1] ? mag_t'(-x) : mag_t'(x);
  endfunction

  function automatic data_t mul_q(logic neg, prod_t p);
    mag_t m;
    m = p[DW+FB-1:FB];
    if ((p[2*DW-1:DW+FB] != '0) || m[DW-1]) return neg ? SMIN : SMAX;
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

[hdl/pidrs_div.sv]
// Radix-2 restoring divider computing (num << FB) / den, saturated to all ones.
// One quotient bit per cycle; a zero divisor or overflow finishes at once.
// Depends on pidrs_pkg.
module pidrs_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pidrs_pkg::mag_t  num_i,
  input  pidrs_pkg::mag_t  den_i,
  output logic             done_o,
  output pidrs_pkg::mag_t  quo_o
);

  localparam int CNT_W = $clog2(pidrs_pkg::DW + 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CNT_W-1:0]        cnt_q;
  pidrs_pkg::mag_t         rem_q;
  pidrs_pkg::mag_t         shf_q;
  pidrs_pkg::mag_t         quo_q;
  pidrs_pkg::mag_t         den_q;
  logic [pidrs_pkg::DW:0]  trial;
  logic [pidrs_pkg::DW:0]  diff;
  logic                    fits;
  logic                    ovf;

  assign trial = {rem_q, shf_q[pidrs_pkg::DW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});
  assign ovf   = (den_i == '0) ||
                 (pidrs_pkg::mag_t'(num_i[pidrs_pkg::DW-1:pidrs_pkg::FB]) >= den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (ovf) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(pidrs_pkg::DW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= pidrs_pkg::mag_t'(num_i[pidrs_pkg::DW-1:pidrs_pkg::FB]);
      shf_q <= {num_i[pidrs_pkg::FB-1:0], {pidrs_pkg::FB{1'b0}}};
      quo_q <= ovf ? '1 : '0;
    end else if (busy_q) begin
      rem_q <= fits ? diff[pidrs_pkg::DW-1:0] : trial[pidrs_pkg::DW-1:0];
      shf_q <= {shf_q[pidrs_pkg::DW-2:0], 1'b0};
      quo_q <= {quo_q[pidrs_pkg::DW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

[hdl/pid_controller_rate_scaled.sv]
// Rate-scaled PID controller, signed Q16.16, one shared multiplier and divider.
// Per sample: error, proportional term, rate quotient, integral, integral term, and with nonzero
// d_gain a second quotient and the derivative terms; a saturating quotient skips the divider
// iterations. A loop-reset item returns the cycle after accept; one item is processed at a time.
// Reset: asynchronous, clears registers, loop state and the output valid; prev_rate is 1.0.
// Depends on pidrs_pkg and pidrs_div.
module pid_controller_rate_scaled (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,  // command, actual, rate
  input  logic                          s_axis_tuser,  // op
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // drive
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pidrs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  typedef enum logic [19:0] {
    S_IDLE = 20'h00001,
    S_ERR  = 20'h00002,
    S_MULP = 20'h00004,
    S_TRMP = 20'h00008,
    S_DIV  = 20'h00010,
    S_MULE = 20'h00020,
    S_TRME = 20'h00040,
    S_INT  = 20'h00080,
    S_ICLP = 20'h00100,
    S_MULI = 20'h00200,
    S_TRMI = 20'h00400,
    S_ACCI = 20'h00800,
    S_DIFF = 20'h01000,
    S_MULD = 20'h02000,
    S_TRMD = 20'h04000,
    S_DCLP = 20'h08000,
    S_MULG = 20'h10000,
    S_TRMG = 20'h20000,
    S_ACCD = 20'h40000,
    S_OCLP = 20'h80000
  } state_e;

  state_e                state_q, state_d;
  logic                  dsel_q;
  logic                  out_valid_q;
  pidrs_pkg::data_t      p_gain_q, i_gain_q, d_gain_q;
  pidrs_pkg::lim_t       int_lim_q, der_lim_q, out_lim_q;
  pidrs_pkg::data_t      integral_q, prev_error_q;
  pidrs_pkg::mag_t       prev_rate_q;
  pidrs_pkg::data_t      cmd_q, act_q, err_q, term_q, acc_q, drive_q;
  pidrs_pkg::mag_t       rate_q, ratio_q;
  pidrs_pkg::prod_t      prod_q;
  logic                  neg_q;

  logic                  accept;
  logic                  slot_free;
  logic                  cfg_we;
  logic [2:0]            reg_idx;
  logic                  div_start;
  logic                  div_done;
  pidrs_pkg::mag_t       div_num;
  pidrs_pkg::mag_t       div_den;
  pidrs_pkg::mag_t       div_quo;
  pidrs_pkg::mag_t       mul_a, mul_b;
  logic                  mul_neg;
  pidrs_pkg::data_t      term_val;

  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && slot_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;
  assign pready        = 1'b1;
  assign cfg_we        = psel && penable && pwrite;
  assign reg_idx       = paddr[4:2];
  assign term_val      = pidrs_pkg::mul_q(neg_q, prod_q);

  assign div_start = (state_q == S_TRMP) || (state_q == S_DIFF);
  assign div_num   = (state_q == S_DIFF) ? rate_q : prev_rate_q;
  assign div_den   = (state_q == S_DIFF) ? prev_rate_q : rate_q;

  pidrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_comb begin
    case (reg_idx)
      pidrs_pkg::REG_P_GAIN:  prdata = p_gain_q;
      pidrs_pkg::REG_I_GAIN:  prdata = i_gain_q;
      pidrs_pkg::REG_D_GAIN:  prdata = d_gain_q;
      pidrs_pkg::REG_INT_LIM: prdata = {1'b0, int_lim_q};
      pidrs_pkg::REG_DER_LIM: prdata = {1'b0, der_lim_q};
      pidrs_pkg::REG_OUT_LIM: prdata = {1'b0, out_lim_q};
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    mul_a   = pidrs_pkg::mag(err_q);
    mul_b   = pidrs_pkg::mag(p_gain_q);
    mul_neg = err_q[31] ^ p_gain_q[31];
    case (state_q)
      S_MULE: begin
        mul_a   = pidrs_pkg::mag(err_q);
        mul_b   = ratio_q;
        mul_neg = err_q[31];
      end
      S_MULI: begin
        mul_a   = pidrs_pkg::mag(integral_q);
        mul_b   = pidrs_pkg::mag(i_gain_q);
        mul_neg = integral_q[31] ^ i_gain_q[31];
      end
      S_MULD: begin
        mul_a   = pidrs_pkg::mag(term_q);
        mul_b   = ratio_q;
        mul_neg = term_q[31];
      end
      S_MULG: begin
        mul_a   = pidrs_pkg::mag(term_q);
        mul_b   = pidrs_pkg::mag(d_gain_q);
        mul_neg = term_q[31] ^ d_gain_q[31];
      end
      default: begin
        mul_a   = pidrs_pkg::mag(err_q);
        mul_b   = pidrs_pkg::mag(p_gain_q);
        mul_neg = err_q[31] ^ p_gain_q[31];
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept && !s_axis_tuser) state_d = S_ERR;
      S_ERR:  state_d = S_MULP;
      S_MULP: state_d = S_TRMP;
      S_TRMP: state_d = S_DIV;
      S_DIV:  if (div_done) state_d = dsel_q ? S_MULD : S_MULE;
      S_MULE: state_d = S_TRME;
      S_TRME: state_d = S_INT;
      S_INT:  state_d = S_ICLP;
      S_ICLP: state_d = S_MULI;
      S_MULI: state_d = S_TRMI;
      S_TRMI: state_d = S_ACCI;
      S_ACCI: state_d = (d_gain_q != '0) ? S_DIFF : S_OCLP;
      S_DIFF: state_d = S_DIV;
      S_MULD: state_d = S_TRMD;
      S_TRMD: state_d = S_DCLP;
      S_DCLP: state_d = S_MULG;
      S_MULG: state_d = S_TRMG;
      S_TRMG: state_d = S_ACCD;
      S_ACCD: state_d = S_OCLP;
      S_OCLP: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dsel_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      p_gain_q     <= '0;
      i_gain_q     <= '0;
      d_gain_q     <= '0;
      int_lim_q    <= '0;
      der_lim_q    <= '0;
      out_lim_q    <= '0;
      integral_q   <= '0;
      prev_error_q <= '0;
      prev_rate_q  <= pidrs_pkg::ONE_Q;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        case (reg_idx)
          pidrs_pkg::REG_P_GAIN:  p_gain_q  <= pwdata;
          pidrs_pkg::REG_I_GAIN:  i_gain_q  <= pwdata;
          pidrs_pkg::REG_D_GAIN:  d_gain_q  <= pwdata;
          pidrs_pkg::REG_INT_LIM: int_lim_q <= pwdata[30:0];
          pidrs_pkg::REG_DER_LIM: der_lim_q <= pwdata[30:0];
          pidrs_pkg::REG_OUT_LIM: out_lim_q <= pwdata[30:0];
          default: ;
        endcase
      end
      if ((accept && s_axis_tuser) || ((state_q == S_OCLP) && slot_free)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (accept && s_axis_tuser) begin
        integral_q   <= '0;
        prev_error_q <= '0;
        prev_rate_q  <= pidrs_pkg::ONE_Q;
      end
      case (state_q)
        S_TRMP: dsel_q <= 1'b0;
        S_DIFF: dsel_q <= 1'b1;
        S_ICLP: integral_q <= pidrs_pkg::clamp(term_q, int_lim_q);
        S_ACCD: prev_error_q <= err_q;
        S_OCLP: if (slot_free) prev_rate_q <= rate_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    neg_q  <= mul_neg;
    if (accept) begin
      cmd_q  <= s_axis_tdata[31:0];
      act_q  <= s_axis_tdata[63:32];
      rate_q <= s_axis_tdata[95:64];
      if (s_axis_tuser) drive_q <= '0;
    end
    case (state_q)
      S_ERR:  err_q   <= pidrs_pkg::sat_sub(cmd_q, act_q);
      S_TRMP: acc_q   <= term_val;
      S_DIV:  ratio_q <= div_quo;
      S_TRME: term_q  <= term_val;
      S_INT:  term_q  <= pidrs_pkg::sat_add(integral_q, term_q);
      S_TRMI: term_q  <= term_val;
      S_ACCI: acc_q   <= pidrs_pkg::sat_add(acc_q, term_q);
      S_DIFF: term_q  <= pidrs_pkg::sat_sub(err_q, prev_error_q);
      S_TRMD: term_q  <= term_val;
      S_DCLP: term_q  <= pidrs_pkg::clamp(term_q, der_lim_q);
      S_TRMG: term_q  <= term_val;
      S_ACCD: acc_q   <= pidrs_pkg::sat_add(acc_q, term_q);
      S_OCLP: if (slot_free) drive_q <= pidrs_pkg::clamp(acc_q, out_lim_q);
      default: ;
    endcase
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for pid_controller_rate_scaled: a directed table, then random phases over several
// gain and limit settings; drives are checked against table values or an in-bench fixed-point PID.
// Depends on pidrs_pkg and the controller RTL only.
module tb;

  localparam logic OP_SAMPLE     = 1'b0;
  localparam logic OP_LOOP_RESET = 1'b1;

  localparam int N_DIR       = 18;
  localparam int DIR_CFG_AT  = 5;
  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 242;
  localparam int QUIET_LIMIT = 4000;

  localparam longint          Q_MAX     = 64'sd2147483647;
  localparam longint          Q_MIN     = -64'sd2147483648;
  localparam longint unsigned RATIO_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic               op;
    logic signed [31:0] command;
    logic signed [31:0] actual;
    logic        [31:0] rate;
  } sample_t;

  typedef struct packed {
    sample_t     smp;
    logic        known;
    logic [31:0] drive;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [95:0]                  s_axis_tdata = '0;  // command, actual, rate
  logic                         s_axis_tuser = 1'b0;  // op
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;  // drive
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [pidrs_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;

  always #1 clk_i = ~clk_i;

  pid_controller_rate_scaled u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  longint          kp, ki, kd;
  longint          lim_int, lim_der, lim_out;
  longint          integ, prev_err;
  longint unsigned prev_rate;

  logic [31:0] exp_drive_q [$];
  logic [31:0] exp_drive;
  int          n_errors = 0;
  int          n_results = 0;
  int          n_items = 0;
  int          n_loop_resets = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;

  function automatic longint sat_q(longint a);
    if (a > Q_MAX) return Q_MAX;
    if (a < Q_MIN) return Q_MIN;
    return a;
  endfunction

  function automatic longint unsigned abs_q(longint a);
    return (a < 0) ? -a : a;
  endfunction

  // truncate toward zero, saturate to the data range
  function automatic longint mul_trunc(logic neg, longint unsigned ma, longint unsigned mb);
    longint unsigned m;
    m = (ma * mb) >> pidrs_pkg::FB;
    if (m > Q_MAX) return neg ? Q_MIN : Q_MAX;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint mul_gain(longint a, longint b);
    return mul_trunc((a < 0) != (b < 0), abs_q(a), abs_q(b));
  endfunction

  function automatic longint unsigned rate_ratio(longint unsigned n, longint unsigned d);
    longint unsigned q;
    if (d == 0) return RATIO_MAX;
    q = (n << pidrs_pkg::FB) / d;
    return (q > RATIO_MAX) ? RATIO_MAX : q;
  endfunction

  function automatic longint limit_q(longint x, longint lim);
    if (lim == 0) return x;
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic logic [31:0] pid_predict(sample_t s);
    longint          err, acc, diff, dterm;
    longint unsigned rate;
    if (s.op == OP_LOOP_RESET) begin
      integ = 0;
      prev_err = 0;
      prev_rate = pidrs_pkg::ONE_Q;
      return '0;
    end
    rate = s.rate;
    err = sat_q(longint'($signed(s.command)) - longint'($signed(s.actual)));
    acc = mul_gain(kp, err);
    integ = sat_q(integ + mul_trunc(err < 0, abs_q(err), rate_ratio(prev_rate, rate)));
    integ = limit_q(integ, lim_int);
    acc = sat_q(acc + mul_gain(ki, integ));
    if (kd != 0) begin
      diff = sat_q(err - prev_err);
      dterm = mul_trunc(diff < 0, abs_q(diff), rate_ratio(rate, prev_rate));
      dterm = limit_q(dterm, lim_der);
      acc = sat_q(acc + mul_gain(kd, dterm));
      prev_err = err;
    end
    prev_rate = rate;
    acc = limit_q(acc, lim_out);
    return acc[31:0];
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pidrs_pkg::REG_P_GAIN:  kp = $signed(val);
      pidrs_pkg::REG_I_GAIN:  ki = $signed(val);
      pidrs_pkg::REG_D_GAIN:  kd = $signed(val);
      pidrs_pkg::REG_INT_LIM: lim_int = {33'b0, val[30:0]};
      pidrs_pkg::REG_DER_LIM: lim_der = {33'b0, val[30:0]};
      pidrs_pkg::REG_OUT_LIM: lim_out = {33'b0, val[30:0]};
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(input sample_t s, input logic known, input logic [31:0] drive);
    logic [31:0] pred;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {s.rate, s.actual, s.command};
    s_axis_tuser <= s.op;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = pid_predict(s);
    exp_drive_q.push_back(known ? drive : pred);
    n_items++;
    if (s.op == OP_LOOP_RESET) n_loop_resets++;
  endtask

  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    while (exp_drive_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (exp_drive_q.size() == 0) begin
        $display("%0t: unexpected drive item, expected none, got %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        exp_drive = exp_drive_q.pop_front();
        if (m_axis_tdata !== exp_drive) begin
          $display("%0t: drive mismatch, expected %h, got %h", $time, exp_drive, m_axis_tdata);
          n_errors++;
        end
      end
    end
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t    dir_tab [N_DIR];
    sample_t     smp;
    logic [31:0] cfg [8];

    dir_tab = '{
      '{'{OP_SAMPLE, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000}, 1'b1, 32'h0},
      '{'{OP_SAMPLE, pidrs_pkg::SMAX, pidrs_pkg::SMIN, 32'hFFFF_FFFF}, 1'b1, 32'h0},
      '{'{OP_SAMPLE, pidrs_pkg::SMIN, pidrs_pkg::SMAX, 32'h0000_0001}, 1'b1, 32'h0},
      '{'{OP_SAMPLE, 32'h0002_0000, 32'hFFFF_0000, 32'h0000_0000}, 1'b1, 32'h0},
      '{'{OP_LOOP_RESET, 32'h0, 32'h0, 32'h0}, 1'b1, 32'h0},
      '{'{OP_LOOP_RESET, 32'h0, 32'h0, 32'h0001_0000}, 1'b1, 32'h0},
      '{'{OP_SAMPLE, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'h0002_0000, 32'h0000_8000, 32'h0002_0000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, pidrs_pkg::SMAX, pidrs_pkg::SMIN, 32'h0001_0000}, 1'b1, 32'h0064_0000},
      '{'{OP_SAMPLE, pidrs_pkg::SMIN, pidrs_pkg::SMAX, 32'h0001_0000}, 1'b1, 32'hFF9C_0000},
      '{'{OP_SAMPLE, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'h0000_7FFF, 32'hFFFF_8001, 32'hFFFF_FFFF}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'hFFFE_0000, 32'h0003_0000, 32'h0000_0001}, 1'b0, 32'h0},
      '{'{OP_LOOP_RESET, pidrs_pkg::SMAX, pidrs_pkg::SMIN, 32'hFFFF_FFFF}, 1'b1, 32'h0},
      '{'{OP_SAMPLE, 32'h1234_5678, 32'h1234_5678, 32'h0001_0000}, 1'b0, 32'h0},
      '{'{OP_SAMPLE, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000}, 1'b0, 32'h0}
    };

    kp = 0;
    ki = 0;
    kd = 0;
    lim_int = 0;
    lim_der = 0;
    lim_out = 0;
    integ = 0;
    prev_err = 0;
    prev_rate = pidrs_pkg::ONE_Q;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (i == DIR_CFG_AT) begin
        drain_outputs();
        write_reg(pidrs_pkg::REG_P_GAIN, 32'h0001_0000);
        write_reg(pidrs_pkg::REG_I_GAIN, 32'h0000_8000);
        write_reg(pidrs_pkg::REG_D_GAIN, 32'hFFFF_C000);
        write_reg(pidrs_pkg::REG_INT_LIM, 32'h0032_0000);
        write_reg(pidrs_pkg::REG_DER_LIM, 32'h0000_0000);
        write_reg(pidrs_pkg::REG_OUT_LIM, 32'h0064_0000);
      end
      send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].drive);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_outputs();
      case (ph)
        0: begin
          cfg[pidrs_pkg::REG_P_GAIN] = 32'h0001_0000;
          cfg[pidrs_pkg::REG_I_GAIN] = 32'h0000_1000;
          cfg[pidrs_pkg::REG_D_GAIN] = 32'h0;
          cfg[pidrs_pkg::REG_INT_LIM] = 32'h0;
          cfg[pidrs_pkg::REG_DER_LIM] = 32'h0;
          cfg[pidrs_pkg::REG_OUT_LIM] = 32'h0;
        end
        1: begin
          cfg[pidrs_pkg::REG_P_GAIN] = 32'h0000_8000;
          cfg[pidrs_pkg::REG_I_GAIN] = 32'h0000_4000;
          cfg[pidrs_pkg::REG_D_GAIN] = 32'h0000_2000;
          cfg[pidrs_pkg::REG_INT_LIM] = 32'h000A_0000;
          cfg[pidrs_pkg::REG_DER_LIM] = 32'h0005_0000;
          cfg[pidrs_pkg::REG_OUT_LIM] = 32'h0014_0000;
        end
        2: begin
          cfg[pidrs_pkg::REG_P_GAIN] = 32'h7FFF_FFFF;
          cfg[pidrs_pkg::REG_I_GAIN] = 32'h8000_0000;
          cfg[pidrs_pkg::REG_D_GAIN] = 32'h8000_0000;
          cfg[pidrs_pkg::REG_INT_LIM] = 32'h7FFF_FFFF;
          cfg[pidrs_pkg::REG_DER_LIM] = 32'h7FFF_FFFF;
          cfg[pidrs_pkg::REG_OUT_LIM] = 32'h7FFF_FFFF;
        end
        3: begin
          cfg[pidrs_pkg::REG_P_GAIN] = $urandom;
          cfg[pidrs_pkg::REG_I_GAIN] = $urandom;
          cfg[pidrs_pkg::REG_D_GAIN] = $urandom | 32'h1;
          cfg[pidrs_pkg::REG_INT_LIM] = $urandom_range(1, 32'h0001_0000);
          cfg[pidrs_pkg::REG_DER_LIM] = $urandom_range(1, 32'h0001_0000);
          cfg[pidrs_pkg::REG_OUT_LIM] = $urandom_range(1, 32'h0001_0000);
        end
        4: begin
          cfg[pidrs_pkg::REG_P_GAIN] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          cfg[pidrs_pkg::REG_I_GAIN] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          cfg[pidrs_pkg::REG_D_GAIN] =
            ($urandom_range(0, 32'h0008_0000) - 32'h0004_0000) | 32'h1;
          cfg[pidrs_pkg::REG_INT_LIM] = 32'h1;
          cfg[pidrs_pkg::REG_DER_LIM] = 32'h1;
          cfg[pidrs_pkg::REG_OUT_LIM] = 32'h1;
        end
        5: begin
          cfg[pidrs_pkg::REG_P_GAIN] = 32'hFFFF_0000;
          cfg[pidrs_pkg::REG_I_GAIN] = 32'hFFFF_C000;
          cfg[pidrs_pkg::REG_D_GAIN] = 32'hFFFE_0000;
          cfg[pidrs_pkg::REG_INT_LIM] = $urandom_range(0, 32'h7FFF_FFFF);
          cfg[pidrs_pkg::REG_DER_LIM] = $urandom_range(0, 32'h7FFF_FFFF);
          cfg[pidrs_pkg::REG_OUT_LIM] = $urandom_range(0, 32'h7FFF_FFFF);
        end
        6: begin
          cfg[pidrs_pkg::REG_P_GAIN] = $urandom;
          cfg[pidrs_pkg::REG_I_GAIN] = $urandom;
          cfg[pidrs_pkg::REG_D_GAIN] = $urandom;
          cfg[pidrs_pkg::REG_INT_LIM] = $urandom;
          cfg[pidrs_pkg::REG_DER_LIM] = $urandom;
          cfg[pidrs_pkg::REG_OUT_LIM] = $urandom;
        end
        default: begin
          cfg[pidrs_pkg::REG_P_GAIN] = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          cfg[pidrs_pkg::REG_I_GAIN] = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
          cfg[pidrs_pkg::REG_D_GAIN] =
            ($urandom_range(0, 32'h0002_0000) - 32'h0001_0000) | 32'h1;
          cfg[pidrs_pkg::REG_INT_LIM] = $urandom_range(32'h0001_0000, 32'h0100_0000);
          cfg[pidrs_pkg::REG_DER_LIM] = $urandom_range(32'h0001_0000, 32'h0100_0000);
          cfg[pidrs_pkg::REG_OUT_LIM] = $urandom_range(32'h0001_0000, 32'h0100_0000);
        end
      endcase
      for (int r = pidrs_pkg::REG_P_GAIN; r <= pidrs_pkg::REG_OUT_LIM; r++) begin
        write_reg(r[2:0], cfg[r]);
      end
      idle_on = (ph != N_PHASES - 1) && (ph != 3);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        smp.op = ($urandom_range(0, 39) == 0) ? OP_LOOP_RESET : OP_SAMPLE;
        if ($urandom_range(0, 4) == 0) begin
          smp.command = $urandom;
          smp.actual = $urandom;
        end else begin
          smp.command = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
          smp.actual = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
        end
        case ($urandom_range(0, 9))
          0: smp.rate = $urandom;
          1: begin
            case ($urandom_range(0, 3))
              0: smp.rate = 32'h0;
              1: smp.rate = 32'h1;
              2: smp.rate = 32'hFFFF_FFFF;
              default: smp.rate = pidrs_pkg::ONE_Q;
            endcase
          end
          default: smp.rate = $urandom_range(32'h0000_4000, 32'h0004_0000);
        endcase
        send_sample(smp, 1'b0, 32'h0);
      end
    end

    drain_outputs();
    repeat (100) @(posedge clk_i);
    $display("Sent %0d items (%0d loop resets) over %0d register settings, %0d drives checked.",
             n_items, n_loop_resets, N_PHASES + 2, n_results);
    $display("Gains ran from zero to full scale, limits from one LSB to unlimited.");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[pid_controller_rate_scaled.f]
hdl/pidrs_pkg.sv
hdl/pidrs_div.sv
hdl/pid_controller_rate_scaled.sv
sim/tb.sv
